### design/ipf_pkg.sv
package ipf_pkg;

  localparam int MAX_RULES = 64;
  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 6;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);

  localparam logic [LEN_W-1:0] FULL_LEN     = LEN_W'(ADDR_W);
  localparam logic [LEN_W-1:0] NO_MATCH_LEN = LEN_W'(ADDR_W + 1);
  localparam logic [LEN_W-1:0] DEFAULT_LEN  = '0;
  localparam logic [CNT_W-1:0] RULES_FULL   = CNT_W'(MAX_RULES);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_len;
    logic              action;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic              deny;
  } rule_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic direct;
    logic scan_last;
    logic out_busy;
  } dp_sts_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    prefix_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

### design/ipf_if.sv
interface ipf_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [ipf_pkg::ADDR_W-1:0] address;
  logic [ipf_pkg::LEN_W-1:0]  prefix_len;
  logic                      action;

  modport source(output valid, output req_type, output address, output prefix_len,
                 output action, input ready);
  modport sink(input valid, input req_type, input address, input prefix_len,
               input action, output ready);
endinterface

interface ipf_rsp_if;
  logic valid;
  logic ready;
  logic permit;
  logic status;

  modport source(output valid, output permit, output status, input ready);
  modport sink(input valid, input permit, input status, output ready);
endinterface

### design/ipf_ctrl.sv
module ipf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ipf_pkg::dp_sts_t   sts,
  output ipf_pkg::ctl_cmd_t  cmd
);

  ipf_pkg::state_t state_r;
  ipf_pkg::state_t state_nxt;

  assign in_ready = (state_r == ipf_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ipf_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.direct ? ipf_pkg::S_FIN : ipf_pkg::S_SCAN;
        end
      end
      ipf_pkg::S_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ipf_pkg::S_DRAIN;
        end
      end
      ipf_pkg::S_DRAIN: begin
        state_nxt = ipf_pkg::S_FIN;
      end
      ipf_pkg::S_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = ipf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ipf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/ipf_dpath.sv
module ipf_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  ipf_pkg::req_t      in_req,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_permit,
  output logic               out_status,
  input  ipf_pkg::ctl_cmd_t  cmd,
  output ipf_pkg::dp_sts_t   sts
);

  ipf_pkg::rule_t rule_mem [ipf_pkg::MAX_RULES];

  logic [ipf_pkg::CNT_W-1:0]  count_r;
  logic                       default_deny_r;
  logic                       req_type_r;
  logic [ipf_pkg::ADDR_W-1:0] addr_r;
  logic [ipf_pkg::ADDR_W-1:0] pfx_r;
  logic [ipf_pkg::LEN_W-1:0]  len_r;
  logic                       act_r;
  logic [ipf_pkg::IDX_W-1:0]  scan_idx_r;
  logic [ipf_pkg::IDX_W-1:0]  cmp_idx_r;
  logic                       rd_vld_r;
  ipf_pkg::rule_t             rd_rule_r;
  logic [ipf_pkg::LEN_W-1:0]  best_len_r;
  logic                       verdict_r;
  logic                       hit_r;
  logic [ipf_pkg::IDX_W-1:0]  hit_idx_r;
  logic                       out_valid_r;
  logic                       out_permit_r;
  logic                       out_status_r;

  logic [ipf_pkg::LEN_W-1:0]  in_len_sat;
  logic                       ins_match;
  logic                       qry_match;
  logic                       is_default;
  logic                       tbl_full;
  logic                       wr_en;
  logic [ipf_pkg::IDX_W-1:0]  wr_idx;
  ipf_pkg::rule_t             wr_rule;

  assign in_len_sat = (in_req.prefix_len > ipf_pkg::FULL_LEN) ? ipf_pkg::FULL_LEN
                                                              : in_req.prefix_len;

  assign sts.direct    = ((in_req.req_type == ipf_pkg::REQ_INSERT) &&
                          (in_req.prefix_len == ipf_pkg::DEFAULT_LEN)) ||
                         (count_r == '0);
  assign sts.scan_last = (ipf_pkg::CNT_W'(scan_idx_r) == (count_r - ipf_pkg::CNT_W'(1)));
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign ins_match = (rd_rule_r.len == len_r) && (rd_rule_r.prefix == pfx_r);
  assign qry_match = ((addr_r & ipf_pkg::prefix_mask(rd_rule_r.len)) == rd_rule_r.prefix) &&
                     (rd_rule_r.len < best_len_r);

  assign is_default = (req_type_r == ipf_pkg::REQ_INSERT) && (len_r == ipf_pkg::DEFAULT_LEN);
  assign tbl_full   = (count_r == ipf_pkg::RULES_FULL);
  assign wr_en      = cmd.fin && (req_type_r == ipf_pkg::REQ_INSERT) && !is_default &&
                      (hit_r || !tbl_full);
  assign wr_idx     = hit_r ? hit_idx_r : count_r[ipf_pkg::IDX_W-1:0];
  assign wr_rule    = '{prefix: pfx_r, len: len_r, deny: act_r};

  // rule memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_mem[wr_idx] <= wr_rule;
    end
    if (cmd.rd) begin
      rd_rule_r <= rule_mem[scan_idx_r];
    end
  end

  // request latch and scan state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req.req_type;
      addr_r     <= in_req.address;
      len_r      <= in_len_sat;
      pfx_r      <= in_req.address & ipf_pkg::prefix_mask(in_len_sat);
      act_r      <= in_req.action;
      best_len_r <= ipf_pkg::NO_MATCH_LEN;
      verdict_r  <= default_deny_r;
      hit_idx_r  <= '0;
    end else if (rd_vld_r) begin
      if (req_type_r == ipf_pkg::REQ_QUERY) begin
        if (qry_match) begin
          best_len_r <= rd_rule_r.len;
          verdict_r  <= rd_rule_r.deny;
        end
      end else if (ins_match) begin
        hit_idx_r <= cmp_idx_r;
      end
    end
    if (cmd.rd) begin
      cmp_idx_r <= scan_idx_r;
    end
    out_permit_r <= cmd.fin ? ((req_type_r == ipf_pkg::REQ_QUERY) && !verdict_r)
                            : out_permit_r;
    out_status_r <= cmd.fin ? ((req_type_r == ipf_pkg::REQ_INSERT) && !is_default &&
                               !hit_r && tbl_full) : out_status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r        <= '0;
      default_deny_r <= 1'b0;
      scan_idx_r     <= '0;
      rd_vld_r       <= 1'b0;
      hit_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (cmd.load) begin
        scan_idx_r <= '0;
        hit_r      <= 1'b0;
      end else begin
        if (cmd.rd) begin
          scan_idx_r <= scan_idx_r + ipf_pkg::IDX_W'(1);
        end
        if (rd_vld_r && (req_type_r == ipf_pkg::REQ_INSERT) && ins_match) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.fin && is_default) begin
        default_deny_r <= act_r;
      end
      if (wr_en && !hit_r) begin
        count_r <= count_r + ipf_pkg::CNT_W'(1);
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_permit = out_permit_r;
  assign out_status = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ipf_pkg::RULES_FULL)
    else $error("rule count above table size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> !(out_valid_r && !out_ready))
    else $error("result register overwritten before transfer");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (ipf_pkg::CNT_W'(cmp_idx_r) < count_r))
    else $error("scan read beyond stored rules");

  a_new_rule_append: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !hit_r) |-> !tbl_full)
    else $error("new rule written into full table");

endmodule

### design/ip_prefix_rule_filter.sv
// IPv4 prefix access filter. Each input transfer is an insert (req_type 0) or a query
// (req_type 1) and yields exactly one result transfer. An insert with prefix_len 0 sets
// the default action; lengths above 32 count as 32; an insert matching a stored prefix
// and length overwrites its action, otherwise it takes a new entry, and status is 1 when
// the 64-entry table is full. A query returns the action of the shortest matching stored
// prefix, or the default (allow after reset). Items are handled one at a time: each item
// is compared with the stored rules, which are scanned through the single read port of
// the rule memory at one entry per cycle, before its result is registered; a default-action
// insert or any item on an empty table skips the scan. A waiting result is held in an
// output register while the next item is taken.
module ip_prefix_rule_filter (
  input logic       clk,
  input logic       rst_n,
  ipf_req_if.sink   in_if,
  ipf_rsp_if.source out_if
);

  ipf_pkg::req_t     in_req;
  ipf_pkg::ctl_cmd_t cmd;
  ipf_pkg::dp_sts_t  sts;

  assign in_req = '{req_type:   in_if.req_type,
                    address:    in_if.address,
                    prefix_len: in_if.prefix_len,
                    action:     in_if.action};

  ipf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipf_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .out_ready  (out_if.ready),
    .out_valid  (out_if.valid),
    .out_permit (out_if.permit),
    .out_status (out_if.status),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

### sim/testbench.sv
module testbench;

  localparam int RX_HOLD    = 300;
  localparam int QUIET_MAX  = 3000;
  localparam int N_RANDOM   = 1300;
  localparam int TAIL_WAIT  = 80;

  typedef struct packed {
    logic permit;
    logic status;
  } verdict_t;

  typedef struct {
    ipf_pkg::req_t req;
    int unsigned   gap;
    bit            drain;
    bit            hold_rx;
  } pending_t;

  logic clk;
  logic rst_n;

  ipf_req_if req_ch ();
  ipf_rsp_if rsp_ch ();

  ip_prefix_rule_filter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // predictor state
  logic [ipf_pkg::ADDR_W-1:0] tbl_prefix [ipf_pkg::MAX_RULES];
  logic [ipf_pkg::LEN_W-1:0]  tbl_len    [ipf_pkg::MAX_RULES];
  logic                       tbl_deny   [ipf_pkg::MAX_RULES];
  int                         tbl_count;
  logic                       dflt_deny;

  verdict_t      verdicts_due [$];
  pending_t      pending [$];
  pending_t      nxt;
  ipf_pkg::req_t cur_req;
  bit            offering;
  bit            have_next;
  int unsigned   gap_left;
  logic          req_taken;
  int unsigned   hold_token;
  int unsigned   hold_seen;
  int unsigned   hold_left;
  int unsigned   rx_gap;
  int unsigned   calm_left;
  int unsigned   quiet;

  int errors;
  int n_results;
  int n_insert;
  int n_query;
  int n_dropped;
  int n_allowed;
  int n_denied;
  int n_overwrite;

  // generator bookkeeping
  logic [ipf_pkg::ADDR_W-1:0] pool_addr [$];
  logic [ipf_pkg::LEN_W-1:0]  pool_len  [$];
  logic [ipf_pkg::ADDR_W-1:0] roots [4];

  function automatic logic [ipf_pkg::ADDR_W-1:0] len_mask(logic [ipf_pkg::LEN_W-1:0] len);
    logic [ipf_pkg::ADDR_W-1:0] m;
    m = '0;
    for (int b = 0; b < ipf_pkg::ADDR_W; b++)
      if (b < len)
        m[ipf_pkg::ADDR_W-1-b] = 1'b1;
    return m;
  endfunction

  function automatic verdict_t filter_apply(ipf_pkg::req_t r);
    verdict_t                   v;
    logic [ipf_pkg::LEN_W-1:0]  len;
    logic [ipf_pkg::LEN_W-1:0]  best;
    logic [ipf_pkg::ADDR_W-1:0] pfx;
    logic                       deny;
    bit                         hit;
    v = '{permit: 1'b0, status: ipf_pkg::STATUS_OK};
    if (r.req_type == ipf_pkg::REQ_INSERT) begin
      n_insert++;
      if (r.prefix_len == ipf_pkg::DEFAULT_LEN) begin
        dflt_deny = r.action;
      end else begin
        len = (r.prefix_len > ipf_pkg::FULL_LEN) ? ipf_pkg::FULL_LEN : r.prefix_len;
        pfx = r.address & len_mask(len);
        hit = 1'b0;
        for (int i = 0; i < tbl_count; i++) begin
          if (!hit && tbl_len[i] == len && tbl_prefix[i] == pfx) begin
            tbl_deny[i] = r.action;
            hit = 1'b1;
            n_overwrite++;
          end
        end
        if (!hit) begin
          if (tbl_count >= ipf_pkg::MAX_RULES) begin
            v.status = ipf_pkg::STATUS_FULL;
            n_dropped++;
          end else begin
            tbl_prefix[tbl_count] = pfx;
            tbl_len[tbl_count]    = len;
            tbl_deny[tbl_count]   = r.action;
            tbl_count++;
          end
        end
      end
    end else begin
      n_query++;
      best = ipf_pkg::NO_MATCH_LEN;
      deny = dflt_deny;
      for (int i = 0; i < tbl_count; i++) begin
        if ((r.address & len_mask(tbl_len[i])) == tbl_prefix[i] && tbl_len[i] < best) begin
          best = tbl_len[i];
          deny = tbl_deny[i];
        end
      end
      v.permit = !deny;
      if (deny)
        n_denied++;
      else
        n_allowed++;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch on result %0d: %s", n_results, what);
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ipf_pkg::LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return ipf_pkg::LEN_W'($urandom_range(33, 63));
    if (r < 22)
      return ipf_pkg::FULL_LEN;
    if (r < 32)
      return ipf_pkg::LEN_W'($urandom_range(1, 4));
    return ipf_pkg::LEN_W'($urandom_range(1, 31));
  endfunction

  task automatic push_item(logic rt, logic [ipf_pkg::ADDR_W-1:0] a,
                           logic [ipf_pkg::LEN_W-1:0] l, logic act,
                           int unsigned gap, bit drain = 1'b0, bit hold = 1'b0);
    pending_t p;
    p.req.req_type   = rt;
    p.req.address    = a;
    p.req.prefix_len = l;
    p.req.action     = act;
    p.gap            = gap;
    p.drain          = drain;
    p.hold_rx        = hold;
    pending.push_back(p);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (offering && req_taken)
        offering = 1'b0;
      if (!offering && !have_next && pending.size() > 0) begin
        nxt       = pending.pop_front();
        have_next = 1'b1;
        gap_left  = nxt.gap;
      end
      if (!offering && have_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!nxt.drain || verdicts_due.size() == 0) begin
          offering  = 1'b1;
          have_next = 1'b0;
          cur_req   = nxt.req;
          if (nxt.hold_rx)
            hold_token <= hold_token + 1;
        end
      end
      if (!offering)
        cur_req = ipf_pkg::req_t'({$urandom, $urandom});
      req_ch.valid      <= offering;
      req_ch.req_type   <= cur_req.req_type;
      req_ch.address    <= cur_req.address;
      req_ch.prefix_len <= cur_req.prefix_len;
      req_ch.action     <= cur_req.action;
    end
  end

  // result receiver
  always @(negedge clk) begin
    logic take;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      take = 1'b0;
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = RX_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end else begin
        take = 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          rx_gap = idle_len();
          if ($urandom_range(0, 99) < 3)
            calm_left = $urandom_range(50, 300);
        end
      end
      rsp_ch.ready <= take;
    end
  end

  // monitor: check results, then predict newly accepted requests
  always @(posedge clk) begin
    verdict_t      want;
    ipf_pkg::req_t got;
    if (!rst_n) begin
      req_taken <= 1'b0;
      quiet     <= 0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_results++;
        if (verdicts_due.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = verdicts_due.pop_front();
          if (rsp_ch.permit !== want.permit)
            report_mismatch($sformatf("permit %b, expected %b", rsp_ch.permit, want.permit));
          if (rsp_ch.status !== want.status)
            report_mismatch($sformatf("status %b, expected %b", rsp_ch.status, want.status));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        got.req_type   = req_ch.req_type;
        got.address    = req_ch.address;
        got.prefix_len = req_ch.prefix_len;
        got.action     = req_ch.action;
        verdicts_due.push_back(filter_apply(got));
      end
    end
  end

  initial begin
    while (quiet < QUIET_MAX)
      @(posedge clk);
    $display("timeout: no transfer for %0d cycles", QUIET_MAX);
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned                r;
    int unsigned                k;
    int unsigned                calm;
    int unsigned                gap;
    int unsigned                ins_pct;
    logic [ipf_pkg::ADDR_W-1:0] a;
    logic [ipf_pkg::LEN_W-1:0]  l;
    logic                       rt;

    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = ipf_pkg::REQ_INSERT;
    req_ch.address    = '0;
    req_ch.prefix_len = '0;
    req_ch.action     = 1'b0;
    rsp_ch.ready      = 1'b0;
    req_taken         = 1'b0;
    quiet             = 0;
    offering          = 1'b0;
    have_next         = 1'b0;
    gap_left          = 0;
    hold_token        = 0;
    hold_seen         = 0;
    hold_left         = 0;
    rx_gap            = 0;
    calm_left         = 0;
    cur_req           = '0;
    tbl_count         = 0;
    dflt_deny         = 1'b0;
    errors            = 0;
    n_results         = 0;
    n_insert          = 0;
    n_query           = 0;
    n_dropped         = 0;
    n_allowed         = 0;
    n_denied          = 0;
    n_overwrite       = 0;

    // directed: empty table, default changes, saturation, masking, overwrite
    push_item(ipf_pkg::REQ_QUERY,  32'h0000_0000, 6'd0,  1'b0, 0);
    push_item(ipf_pkg::REQ_QUERY,  32'hFFFF_FFFF, 6'd63, 1'b1, 0);
    push_item(ipf_pkg::REQ_INSERT, 32'hDEAD_BEEF, 6'd0,  1'b1, 0);
    push_item(ipf_pkg::REQ_QUERY,  32'h1234_5678, 6'd0,  1'b0, 1);
    push_item(ipf_pkg::REQ_INSERT, 32'h0000_0000, 6'd0,  1'b0, 0);
    push_item(ipf_pkg::REQ_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b1, 0);
    push_item(ipf_pkg::REQ_QUERY,  32'hFFFF_FFFF, 6'd0,  1'b0, 0);
    push_item(ipf_pkg::REQ_QUERY,  32'hFFFF_FFFE, 6'd0,  1'b0, 2);
    push_item(ipf_pkg::REQ_INSERT, 32'hC0A8_0155, 6'd16, 1'b1, 0);
    push_item(ipf_pkg::REQ_QUERY,  32'hC0A8_FFFF, 6'd0,  1'b0, 0);
    push_item(ipf_pkg::REQ_INSERT, 32'hC0A8_0100, 6'd24, 1'b0, 0);
    push_item(ipf_pkg::REQ_QUERY,  32'hC0A8_0101, 6'd0,  1'b0, 0);
    push_item(ipf_pkg::REQ_INSERT, 32'h0A00_0001, 6'd33, 1'b1, 0);
    push_item(ipf_pkg::REQ_QUERY,  32'h0A00_0001, 6'd0,  1'b0, 0);
    push_item(ipf_pkg::REQ_INSERT, 32'h0A00_0001, 6'd63, 1'b0, 0);
    push_item(ipf_pkg::REQ_QUERY,  32'h0A00_0001, 6'd21, 1'b1, 0);
    push_item(ipf_pkg::REQ_INSERT, 32'h8000_0000, 6'd1,  1'b1, 3);
    push_item(ipf_pkg::REQ_QUERY,  32'h7FFF_FFFF, 6'd0,  1'b0, 0);
    push_item(ipf_pkg::REQ_QUERY,  32'h8000_0000, 6'd0,  1'b0, 0);
    push_item(ipf_pkg::REQ_INSERT, 32'hC0A8_FFFF, 6'd16, 1'b0, 0);
    push_item(ipf_pkg::REQ_QUERY,  32'hC0A8_0001, 6'd0,  1'b0, 0);
    push_item(ipf_pkg::REQ_INSERT, 32'h0000_0000, 6'd0,  1'b1, 0);
    push_item(ipf_pkg::REQ_QUERY,  32'h4000_0000, 6'd0,  1'b0, 0);
    push_item(ipf_pkg::REQ_INSERT, 32'h0000_0000, 6'd0,  1'b0, 0);
    pool_addr = '{32'hC0A8_0155, 32'hC0A8_0100, 32'h0A00_0001, 32'h8000_0000};
    pool_len  = '{6'd16, 6'd24, 6'd32, 6'd1};

    for (int j = 0; j < 4; j++)
      roots[j] = $urandom;

    calm = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (calm > 0) begin
        calm--;
        gap = 0;
      end else begin
        gap = idle_len();
        if ($urandom_range(0, 99) < 2)
          calm = $urandom_range(20, 80);
      end
      ins_pct = (i < 400) ? 20 : 35;
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
        rt = ipf_pkg::REQ_INSERT;
        r  = $urandom_range(0, 99);
        if (r < 5) begin
          a = $urandom;
          l = ipf_pkg::DEFAULT_LEN;
        end else if (r < 35) begin
          k = $urandom_range(0, pool_addr.size() - 1);
          l = pool_len[k];
          a = pool_addr[k] ^ ($urandom & ~len_mask(l));
          if (l == ipf_pkg::FULL_LEN && $urandom_range(0, 1) == 1)
            l = ipf_pkg::LEN_W'($urandom_range(33, 63));
        end else begin
          l = pick_len();
          a = roots[$urandom_range(0, 3)] ^
              ($urandom & ~len_mask(ipf_pkg::LEN_W'($urandom_range(0, 32))));
          pool_addr.push_back(a);
          pool_len.push_back((l > ipf_pkg::FULL_LEN) ? ipf_pkg::FULL_LEN : l);
        end
      end else begin
        rt = ipf_pkg::REQ_QUERY;
        l  = ipf_pkg::LEN_W'($urandom);
        if ($urandom_range(0, 99) < 75) begin
          k = $urandom_range(0, pool_addr.size() - 1);
          a = pool_addr[k] ^
              ($urandom & ~len_mask(ipf_pkg::LEN_W'($urandom_range(0, 32))));
        end else begin
          a = $urandom;
        end
      end
      if (i == 350 || i == 900) begin
        // long receiver stall while requests keep coming
        push_item(rt, a, l, $urandom_range(0, 1), 0, 1'b0, 1'b1);
        calm = 40;
      end else begin
        push_item(rt, a, l, $urandom_range(0, 1), gap, (i == 0 || i == 600 || i == 1100));
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() > 0 || have_next || offering)
      @(posedge clk);
    while (verdicts_due.size() > 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("%0d inserts (%0d overwrites, %0d dropped on a full table, %0d rules held)",
             n_insert, n_overwrite, n_dropped, tbl_count);
    $display("%0d queries (%0d allowed, %0d denied), %0d results checked, %0d mismatches",
             n_query, n_allowed, n_denied, n_results, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
